/* rtl/core/dual_encoder_wrap_tuner_top_assert.svh */
// assertion macros for the dual encoder wrap tuner
// expects clk and arst_n in the scope of every use
`ifndef DUAL_ENCODER_WRAP_TUNER_TOP_ASSERT_SVH
`define DUAL_ENCODER_WRAP_TUNER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define DWT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DWT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/dwt_pkg.sv */
// shared types and constants for the dual encoder wrap tuner
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dwt_pkg;

	localparam logic [7:0] COARSE_MIN = 8'd10;
	localparam logic [7:0] COARSE_MAX = 8'd179;
	localparam logic [6:0] FINE_MIN   = 7'd0;
	localparam logic [6:0] FINE_MAX   = 7'd99;
	localparam logic [7:0] HUNDRED    = 8'd100;

	localparam logic [7:0] LEFT_COARSE_RST  = 8'd34;
	localparam logic [7:0] RIGHT_COARSE_RST = 8'd38;
	localparam logic [6:0] FINE_RST         = 7'd1;

	localparam int LEFT_A_BIT  = 0;
	localparam int LEFT_B_BIT  = 1;
	localparam int RIGHT_A_BIT = 2;
	localparam int RIGHT_B_BIT = 3;

	// counter pair of one encoder
	typedef struct packed {
		logic [7:0] coarse;
		logic [6:0] fine;
	} enc_cnt_t;

	// display view of one coarse counter
	typedef struct packed {
		logic       hundred;
		logic [6:0] low_digits;
	} enc_disp_t;

endpackage

`default_nettype wire

/* rtl/core/dwt_enc_step.sv */
// one encoder step: counter update and coarse display digits
// depends on dwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module dwt_enc_step (
	input  wire logic              a_changed,
	input  wire logic              a_pin,
	input  wire logic              b_pin,
	input  wire logic              fine_select,
	input  wire dwt_pkg::enc_cnt_t cnt,
	output dwt_pkg::enc_cnt_t      cnt_next,
	output dwt_pkg::enc_disp_t     disp_next
);

	logic       act;
	logic [7:0] coarse_mv;
	logic [6:0] fine_mv;
	logic [7:0] coarse_less;

	assign act = a_changed & a_pin;

	always_comb begin
		if (b_pin) begin
			coarse_mv = (cnt.coarse == dwt_pkg::COARSE_MAX) ? dwt_pkg::COARSE_MIN
				: cnt.coarse + 8'd1;
			fine_mv   = (cnt.fine == dwt_pkg::FINE_MAX) ? dwt_pkg::FINE_MIN
				: cnt.fine + 7'd1;
		end else begin
			coarse_mv = (cnt.coarse == dwt_pkg::COARSE_MIN) ? dwt_pkg::COARSE_MAX
				: cnt.coarse - 8'd1;
			fine_mv   = (cnt.fine == dwt_pkg::FINE_MIN) ? dwt_pkg::FINE_MAX
				: cnt.fine - 7'd1;
		end
	end

	always_comb begin
		cnt_next = cnt;
		if (act && fine_select) begin
			cnt_next.fine = fine_mv;
		end else if (act) begin
			cnt_next.coarse = coarse_mv;
		end
	end

	// display digits follow the updated coarse count
	always_comb begin
		disp_next.hundred = (cnt_next.coarse >= dwt_pkg::HUNDRED);
		coarse_less       = cnt_next.coarse - dwt_pkg::HUNDRED;
		disp_next.low_digits = disp_next.hundred ? coarse_less[6:0] : cnt_next.coarse[6:0];
	end

endmodule

`default_nettype wire

/* rtl/core/dual_encoder_wrap_tuner_top.sv */
// top level of the dual encoder wrap tuner: input register, state, result register
// depends on dwt_pkg, dwt_enc_step and dual_encoder_wrap_tuner_top_assert.svh
//
// channel | direction | handshake          | payload
// in      | sink      | in_valid/in_stall  | pin_sample, left/right_fine_select
// out     | source    | out_valid/out_stall| coarse, fine, hundred flags, low digits
//
// one word per cycle sustained while out_stall is low; an accepted word passes two registers, input then result
// the rate is set by the combinational counter update between input and result register
// arst_n clears pin history to zero and loads counters with their start values
// out_stall holds the result register; one more input word is taken into the
// input register, then in_stall rises until the result moves on
`timescale 1ns / 1ps
`default_nettype none

module dual_encoder_wrap_tuner_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [3:0] pin_sample,
	input  wire logic       left_fine_select,
	input  wire logic       right_fine_select,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      left_coarse_value,
	output logic [7:0]      right_coarse_value,
	output logic [6:0]      left_fine_value,
	output logic [6:0]      right_fine_value,
	output logic            left_hundred_flag,
	output logic            right_hundred_flag,
	output logic [6:0]      left_low_digits,
	output logic [6:0]      right_low_digits
);

	logic       valid_s1;
	logic [3:0] pins_s1;
	logic       lfine_s1;
	logic       rfine_s1;

	logic [3:0]        prior_pins_q;
	dwt_pkg::enc_cnt_t left_cnt_q;
	dwt_pkg::enc_cnt_t right_cnt_q;

	logic               valid_s2;
	dwt_pkg::enc_cnt_t  left_cnt_s2;
	dwt_pkg::enc_cnt_t  right_cnt_s2;
	dwt_pkg::enc_disp_t left_disp_s2;
	dwt_pkg::enc_disp_t right_disp_s2;

	logic               out_free;
	logic               advance;
	logic               in_take;
	logic [3:0]         changed;
	dwt_pkg::enc_cnt_t  left_cnt_next;
	dwt_pkg::enc_cnt_t  right_cnt_next;
	dwt_pkg::enc_disp_t left_disp_next;
	dwt_pkg::enc_disp_t right_disp_next;

	assign out_free = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;
	assign changed  = pins_s1 ^ prior_pins_q;

	dwt_enc_step u_left (
		.a_changed   (changed[dwt_pkg::LEFT_A_BIT]),
		.a_pin       (pins_s1[dwt_pkg::LEFT_A_BIT]),
		.b_pin       (pins_s1[dwt_pkg::LEFT_B_BIT]),
		.fine_select (lfine_s1),
		.cnt         (left_cnt_q),
		.cnt_next    (left_cnt_next),
		.disp_next   (left_disp_next)
	);

	dwt_enc_step u_right (
		.a_changed   (changed[dwt_pkg::RIGHT_A_BIT]),
		.a_pin       (pins_s1[dwt_pkg::RIGHT_A_BIT]),
		.b_pin       (pins_s1[dwt_pkg::RIGHT_B_BIT]),
		.fine_select (rfine_s1),
		.cnt         (right_cnt_q),
		.cnt_next    (right_cnt_next),
		.disp_next   (right_disp_next)
	);

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			pins_s1  <= pin_sample;
			lfine_s1 <= left_fine_select;
			rfine_s1 <= right_fine_select;
		end
	end

	// encoder state, moves once per word leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_pins_q       <= '0;
			left_cnt_q.coarse  <= dwt_pkg::LEFT_COARSE_RST;
			left_cnt_q.fine    <= dwt_pkg::FINE_RST;
			right_cnt_q.coarse <= dwt_pkg::RIGHT_COARSE_RST;
			right_cnt_q.fine   <= dwt_pkg::FINE_RST;
		end else if (advance) begin
			// b-only changes leave the stored sample alone
			if (changed[dwt_pkg::LEFT_A_BIT] || changed[dwt_pkg::RIGHT_A_BIT]) begin
				prior_pins_q <= pins_s1;
			end
			left_cnt_q  <= left_cnt_next;
			right_cnt_q <= right_cnt_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			left_cnt_s2   <= left_cnt_next;
			right_cnt_s2  <= right_cnt_next;
			left_disp_s2  <= left_disp_next;
			right_disp_s2 <= right_disp_next;
		end
	end

	assign out_valid          = valid_s2;
	assign left_coarse_value  = left_cnt_s2.coarse;
	assign right_coarse_value = right_cnt_s2.coarse;
	assign left_fine_value    = left_cnt_s2.fine;
	assign right_fine_value   = right_cnt_s2.fine;
	assign left_hundred_flag  = left_disp_s2.hundred;
	assign right_hundred_flag = right_disp_s2.hundred;
	assign left_low_digits    = left_disp_s2.low_digits;
	assign right_low_digits   = right_disp_s2.low_digits;

`include "dual_encoder_wrap_tuner_top_assert.svh"

	`DWT_ASSERT_NXT(a_adv_fills_out, advance, valid_s2, "result register not loaded")
	`DWT_ASSERT_NXT(a_hold_state, !advance, $stable(left_cnt_q) && $stable(right_cnt_q),
		"counters moved without a word")
	`DWT_ASSERT_NXT(a_drain, valid_s2 && !out_stall && !valid_s1, !valid_s2,
		"result word repeated")
	`DWT_ASSERT_IMP(a_coarse_range, 1'b1,
		left_cnt_q.coarse >= dwt_pkg::COARSE_MIN && left_cnt_q.coarse <= dwt_pkg::COARSE_MAX
		&& right_cnt_q.coarse >= dwt_pkg::COARSE_MIN
		&& right_cnt_q.coarse <= dwt_pkg::COARSE_MAX, "coarse counter out of range")
	`DWT_ASSERT_IMP(a_fine_range, 1'b1,
		left_cnt_q.fine <= dwt_pkg::FINE_MAX && right_cnt_q.fine <= dwt_pkg::FINE_MAX,
		"fine counter out of range")

endmodule

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 1ps
// testbench for dual_encoder_wrap_tuner_top: encoder pin words in, counter words out
// depends on dwt_pkg and the top level; predicts every counter word and checks it

typedef struct packed {
	logic [7:0] l_coarse;
	logic [7:0] r_coarse;
	logic [6:0] l_fine;
	logic [6:0] r_fine;
	logic       l_hundred;
	logic       r_hundred;
	logic [6:0] l_low;
	logic [6:0] r_low;
} tuner_counts_t;

class encoder_count_tracker;
	logic [3:0]    held_pins;
	logic [7:0]    l_coarse;
	logic [7:0]    r_coarse;
	logic [6:0]    l_fine;
	logic [6:0]    r_fine;
	tuner_counts_t expected_counts[$];
	int            samples_noted;
	int            counts_checked;
	int            mismatches;
	int            steps;
	int            coarse_wraps;
	int            fine_wraps;

	function new();
		held_pins = '0;
		l_coarse = dwt_pkg::LEFT_COARSE_RST;
		r_coarse = dwt_pkg::RIGHT_COARSE_RST;
		l_fine = dwt_pkg::FINE_RST;
		r_fine = dwt_pkg::FINE_RST;
		samples_noted = 0;
		counts_checked = 0;
		mismatches = 0;
		steps = 0;
		coarse_wraps = 0;
		fine_wraps = 0;
	endfunction

	function logic [7:0] coarse_turn(logic [7:0] v, logic up);
		if (up && v == dwt_pkg::COARSE_MAX) begin
			coarse_wraps++;
			return dwt_pkg::COARSE_MIN;
		end
		if (!up && v == dwt_pkg::COARSE_MIN) begin
			coarse_wraps++;
			return dwt_pkg::COARSE_MAX;
		end
		return up ? v + 8'd1 : v - 8'd1;
	endfunction

	function logic [6:0] fine_turn(logic [6:0] v, logic up);
		if (up && v == dwt_pkg::FINE_MAX) begin
			fine_wraps++;
			return dwt_pkg::FINE_MIN;
		end
		if (!up && v == dwt_pkg::FINE_MIN) begin
			fine_wraps++;
			return dwt_pkg::FINE_MAX;
		end
		return up ? v + 7'd1 : v - 7'd1;
	endfunction

	function logic [6:0] low_digits(logic [7:0] v);
		logic [7:0] d;
		d = (v >= dwt_pkg::HUNDRED) ? v - dwt_pkg::HUNDRED : v;
		return d[6:0];
	endfunction

	// one accepted pin word gives exactly one counter word
	function void note_sample(logic [3:0] pins, logic lf, logic rf);
		logic [3:0]    moved;
		tuner_counts_t want;
		moved = pins ^ held_pins;
		if (moved[dwt_pkg::LEFT_A_BIT]) begin
			held_pins = pins;
			if (pins[dwt_pkg::LEFT_A_BIT]) begin
				steps++;
				if (lf)
					l_fine = fine_turn(l_fine, pins[dwt_pkg::LEFT_B_BIT]);
				else
					l_coarse = coarse_turn(l_coarse, pins[dwt_pkg::LEFT_B_BIT]);
			end
		end
		if (moved[dwt_pkg::RIGHT_A_BIT]) begin
			held_pins = pins;
			if (pins[dwt_pkg::RIGHT_A_BIT]) begin
				steps++;
				if (rf)
					r_fine = fine_turn(r_fine, pins[dwt_pkg::RIGHT_B_BIT]);
				else
					r_coarse = coarse_turn(r_coarse, pins[dwt_pkg::RIGHT_B_BIT]);
			end
		end
		want.l_coarse = l_coarse;
		want.r_coarse = r_coarse;
		want.l_fine = l_fine;
		want.r_fine = r_fine;
		want.l_hundred = (l_coarse >= dwt_pkg::HUNDRED);
		want.r_hundred = (r_coarse >= dwt_pkg::HUNDRED);
		want.l_low = low_digits(l_coarse);
		want.r_low = low_digits(r_coarse);
		expected_counts.push_back(want);
		samples_noted++;
	endfunction

	function void check_field(string name, int want, int got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	function void check_counts(tuner_counts_t got);
		tuner_counts_t want;
		counts_checked++;
		if (expected_counts.size() == 0) begin
			mismatches++;
			$display("%0t: counter word expected none, got %h", $time, got);
			return;
		end
		want = expected_counts.pop_front();
		check_field("left_coarse_value", int'(want.l_coarse), int'(got.l_coarse));
		check_field("right_coarse_value", int'(want.r_coarse), int'(got.r_coarse));
		check_field("left_fine_value", int'(want.l_fine), int'(got.l_fine));
		check_field("right_fine_value", int'(want.r_fine), int'(got.r_fine));
		check_field("left_hundred_flag", int'(want.l_hundred), int'(got.l_hundred));
		check_field("right_hundred_flag", int'(want.r_hundred), int'(got.r_hundred));
		check_field("left_low_digits", int'(want.l_low), int'(got.l_low));
		check_field("right_low_digits", int'(want.r_low), int'(got.r_low));
	endfunction

	function int pending();
		return expected_counts.size();
	endfunction
endclass

module tb;

	typedef enum {ENC_LEFT, ENC_RIGHT, ENC_BOTH} enc_pick_e;
	typedef enum {SEQ_SWEEP, SEQ_TURN, SEQ_NOISE} seq_kind_e;
	typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [3:0] pin_sample = 4'd0;
	logic       left_fine_select = 1'b0;
	logic       right_fine_select = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] left_coarse_value;
	logic [7:0] right_coarse_value;
	logic [6:0] left_fine_value;
	logic [6:0] right_fine_value;
	logic       left_hundred_flag;
	logic       right_hundred_flag;
	logic [6:0] left_low_digits;
	logic [6:0] right_low_digits;

	encoder_count_tracker tracker = new();

	logic [3:0] cur_pins = 4'd0;
	int         burst_left = 0;
	int         words_sent = 0;
	int         held_cycles = 0;

	dual_encoder_wrap_tuner_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pin_sample(pin_sample),
		.left_fine_select(left_fine_select),
		.right_fine_select(right_fine_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.left_coarse_value(left_coarse_value),
		.right_coarse_value(right_coarse_value),
		.left_fine_value(left_fine_value),
		.right_fine_value(right_fine_value),
		.left_hundred_flag(left_hundred_flag),
		.right_hundred_flag(right_hundred_flag),
		.left_low_digits(left_low_digits),
		.right_low_digits(right_low_digits)
	);

	always #4 clk = ~clk;

	// offers one word, with a random gap whenever a burst runs out
	task automatic send_word(input logic [3:0] pins, input logic lf, input logic rf);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = $urandom_range(1, 40);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pin_sample <= pins;
		left_fine_select <= lf;
		right_fine_select <= rf;
		cur_pins = pins;
		@(posedge clk);
		while (in_stall) begin
			held_cycles++;
			@(posedge clk);
		end
		tracker.note_sample(pins, lf, rf);
		words_sent++;
	endtask

	// each detent drops the A pin with random B, then raises it with B as direction
	task automatic turn_encoders(input enc_pick_e pick, input logic l_up, input logic r_up,
			input logic lf, input logic rf, input int detents);
		logic [3:0] p;
		repeat (detents) begin
			p = cur_pins;
			if (pick != ENC_RIGHT) begin
				p[dwt_pkg::LEFT_A_BIT] = 1'b0;
				p[dwt_pkg::LEFT_B_BIT] = 1'($urandom_range(0, 1));
			end
			if (pick != ENC_LEFT) begin
				p[dwt_pkg::RIGHT_A_BIT] = 1'b0;
				p[dwt_pkg::RIGHT_B_BIT] = 1'($urandom_range(0, 1));
			end
			send_word(p, lf, rf);
			if (pick != ENC_RIGHT) begin
				p[dwt_pkg::LEFT_A_BIT] = 1'b1;
				p[dwt_pkg::LEFT_B_BIT] = l_up;
			end
			if (pick != ENC_LEFT) begin
				p[dwt_pkg::RIGHT_A_BIT] = 1'b1;
				p[dwt_pkg::RIGHT_B_BIT] = r_up;
			end
			send_word(p, lf, rf);
		end
	endtask

	initial begin
		seq_kind_e kind;
		logic      up_first;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bit order is right B, right A, left B, left A
		send_word(4'b0000, 1'b0, 1'b0);	// no change: start values
		send_word(4'b0010, 1'b1, 1'b1);	// B pin alone: ignored
		send_word(4'b0001, 1'b0, 1'b0);	// left coarse down
		send_word(4'b0000, 1'b0, 1'b0);	// A falls: no move
		send_word(4'b0011, 1'b1, 1'b0);	// left fine up
		send_word(4'b1000, 1'b1, 1'b1);	// left A falls, right B rides along
		send_word(4'b1100, 1'b0, 1'b0);	// right coarse up
		send_word(4'b0100, 1'b0, 1'b1);	// right B alone: ignored
		send_word(4'b0000, 1'b0, 1'b0);
		send_word(4'b0101, 1'b0, 1'b0);	// both coarse down
		send_word(4'b0000, 1'b1, 1'b1);
		send_word(4'b1111, 1'b1, 1'b1);	// both fine up
		send_word(4'b1010, 1'b0, 1'b1);
		send_word(4'b0101, 1'b1, 1'b1);	// both fine down
		send_word(4'b1111, 1'b0, 1'b0);	// A pins steady: ignored
		send_word(4'b1110, 1'b1, 1'b0);
		send_word(4'b1101, 1'b1, 1'b0);	// left fine down
		send_word(4'b1100, 1'b1, 1'b0);
		send_word(4'b1101, 1'b1, 1'b0);	// left fine down toward wrap
		send_word(4'b1010, 1'b0, 1'b0);
		send_word(4'b1111, 1'b0, 1'b0);	// both coarse up

		// one full sweep first so both coarse counters wrap, in opposite directions
		up_first = 1'($urandom_range(0, 1));
		turn_encoders(ENC_BOTH, up_first, !up_first, 1'b0, 1'b0, 180);

		while (words_sent < 1400) begin
			case ($urandom_range(0, 11))
				0: kind = SEQ_SWEEP;
				1, 2: kind = SEQ_NOISE;
				default: kind = SEQ_TURN;
			endcase
			case (kind)
				SEQ_SWEEP: begin
					turn_encoders(enc_pick_e'($urandom_range(0, 2)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0,
						$urandom_range(171, 180));
				end
				SEQ_TURN: begin
					turn_encoders(enc_pick_e'($urandom_range(0, 2)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						$urandom_range(1, 40));
				end
				default: begin
					repeat ($urandom_range(1, 8))
						send_word(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
							1'($urandom_range(0, 1)));
				end
			endcase
		end
		in_valid <= 1'b0;

		while (tracker.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d pin words in, %0d counter words checked, %0d encoder steps",
			words_sent, tracker.counts_checked, tracker.steps);
		$display("%0d coarse wraps, %0d fine wraps, input held back for %0d cycles",
			tracker.coarse_wraps, tracker.fine_wraps, held_cycles);
		if (tracker.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// result side: checks each accepted word, stalls on phases of its own
	initial begin
		tuner_counts_t got;
		stall_mode_e   mode;
		int            phase_left;
		int            hold_left;
		bit            held_once;
		logic          nxt;
		mode = STALL_NONE;
		phase_left = 0;
		hold_left = 0;
		held_once = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.l_coarse = left_coarse_value;
				got.r_coarse = right_coarse_value;
				got.l_fine = left_fine_value;
				got.r_fine = right_fine_value;
				got.l_hundred = left_hundred_flag;
				got.r_hundred = right_hundred_flag;
				got.l_low = left_low_digits;
				got.r_low = right_low_digits;
				tracker.check_counts(got);
			end
			// one long hold-off so the pipeline fills and pushes back on the input
			if (!held_once && tracker.samples_noted >= 60) begin
				held_once = 1'b1;
				hold_left = 300;
			end
			if (hold_left > 0) begin
				hold_left--;
				nxt = 1'b1;
			end else begin
				if (phase_left == 0) begin
					mode = stall_mode_e'($urandom_range(0, 3));
					phase_left = $urandom_range(20, 200);
				end
				phase_left--;
				case (mode)
					STALL_NONE: nxt = 1'b0;
					STALL_LIGHT: nxt = ($urandom_range(0, 3) == 0);
					STALL_HEAVY: nxt = ($urandom_range(0, 3) != 0);
					default: nxt = ((phase_left % 4) < 2);
				endcase
			end
			out_stall <= nxt;
		end
	end

	initial begin
		#4000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
